>>> hw/rtl/scm_pkg.sv
// Shared types and constants of the seven-channel sliding median block.
`timescale 1ns / 1ps

package scm_pkg;

  // Operation codes carried in the input word
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Fixed field layout of the input and result words
  localparam int NUM_FIELDS = 7;
  localparam int FIELD_BITS = 32;

  // Control of the shared rank comparator
  typedef struct packed {
    logic clr;
    logic en;
  } rank_ctl_t;

endpackage

>>> hw/rtl/scm_in_if.sv
// Input channel: operation code and one sample per channel.
`timescale 1ns / 1ps

interface scm_in_if;
  import scm_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic signed [FIELD_BITS-1:0] sample_0;
  logic signed [FIELD_BITS-1:0] sample_1;
  logic signed [FIELD_BITS-1:0] sample_2;
  logic signed [FIELD_BITS-1:0] sample_3;
  logic signed [FIELD_BITS-1:0] sample_4;
  logic signed [FIELD_BITS-1:0] sample_5;
  logic signed [FIELD_BITS-1:0] sample_6;

  modport source (
    output valid, operation, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6,
    input  ready
  );

  modport sink (
    input  valid, operation, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6,
    output ready
  );
endinterface

>>> hw/rtl/scm_out_if.sv
// Result channel: one median per channel.
`timescale 1ns / 1ps

interface scm_out_if;
  import scm_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] median_0;
  logic signed [FIELD_BITS-1:0] median_1;
  logic signed [FIELD_BITS-1:0] median_2;
  logic signed [FIELD_BITS-1:0] median_3;
  logic signed [FIELD_BITS-1:0] median_4;
  logic signed [FIELD_BITS-1:0] median_5;
  logic signed [FIELD_BITS-1:0] median_6;

  modport source (
    output valid, median_0, median_1, median_2, median_3, median_4,
           median_5, median_6,
    input  ready
  );

  modport sink (
    input  valid, median_0, median_1, median_2, median_3, median_4,
           median_5, median_6,
    output ready
  );
endinterface

>>> hw/rtl/scm_ring_store.sv
// Ring store of window rows, one row holding a sample of every channel.
`timescale 1ns / 1ps

module scm_ring_store #(
  parameter int WINDOW      = 3,
  parameter int CHANNELS    = 7,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   wr_en_i,
  input  logic [CHANNELS*SAMPLE_BITS-1:0]        wr_row_i,
  input  logic                                   rd_en_i,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] rd_addr_i,
  output logic [CHANNELS*SAMPLE_BITS-1:0]        rd_row_o
);

  localparam int IW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int ROWW = CHANNELS * SAMPLE_BITS;

  logic [ROWW-1:0]   mem [WINDOW];
  logic [WINDOW-1:0] valid_q;
  logic [IW-1:0]     wpos_q;
  logic [ROWW-1:0]   rd_data_q;
  logic              rd_vld_q;

  // Advance the shared write position and mark written rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q   <= '0;
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wpos_q] <= 1'b1;
        if (wpos_q == IW'(WINDOW - 1)) begin
          wpos_q <= '0;
        end else begin
          wpos_q <= wpos_q + 1'b1;
        end
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  // Row memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wpos_q] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Rows never written read as zero
  assign rd_row_o = rd_vld_q ? rd_data_q : '0;

endmodule

>>> hw/rtl/scm_rank_unit.sv
// Shared signed comparator that counts smaller and equal samples.
`timescale 1ns / 1ps

module scm_rank_unit #(
  parameter int SAMPLE_BITS = 32,
  parameter int CNTW        = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scm_pkg::rank_ctl_t            ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] cand_i,
  input  logic signed [SAMPLE_BITS-1:0] value_i,
  output logic [CNTW-1:0]               lt_o,
  output logic [CNTW-1:0]               eq_o
);
  import scm_pkg::*;

  logic [CNTW-1:0] lt_q;
  logic [CNTW-1:0] eq_q;
  logic            lt_hit;
  logic            eq_hit;

  assign lt_hit = (value_i < cand_i);
  assign eq_hit = (value_i == cand_i);

  // Clear at a new candidate, accumulate one compare a step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= '0;
      eq_q <= '0;
    end else if (ctl_i.clr) begin
      lt_q <= '0;
      eq_q <= '0;
    end else if (ctl_i.en) begin
      lt_q <= lt_q + CNTW'(lt_hit);
      eq_q <= eq_q + CNTW'(eq_hit);
    end
  end

  assign lt_o = lt_q;
  assign eq_o = eq_q;

endmodule

>>> hw/rtl/seven_channel_sliding_median.sv
// Top level of the seven-channel sliding-window median filter.
`timescale 1ns / 1ps

// Keeps the last WINDOW samples of up to seven channels in a ring store and
// answers a query word with each channel's median (odd window: middle value;
// even window: mean of the two middle values, rounded toward minus infinity).
// The store resets to zero, so early medians include zeros. A store word is
// taken and gives no result. A query word is worked through by one shared
// comparator that ranks every window entry against every entry, itself
// included, each compare waiting on the fetch of its entry from the row
// memory's single registered read port. The medians are gathered in a result
// register and then moved to the output register, after which the input
// becomes ready again. That move waits only while an earlier result still
// waits in the output register. Unused channels give zero.
module seven_channel_sliding_median #(
  parameter int WINDOW      = 3,
  parameter int CHANNELS    = 7,
  parameter int SAMPLE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  scm_in_if.sink    in_i,
  scm_out_if.source out_o
);
  import scm_pkg::*;

  localparam int IW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNTW = $clog2(WINDOW + 1);
  localparam int ROWW = CHANNELS * SAMPLE_BITS;
  localparam bit ODD  = (WINDOW % 2) == 1;
  localparam int MHI  = WINDOW / 2;
  localparam int MLO  = (WINDOW > 1) ? WINDOW / 2 - 1 : 0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_CAND,
    S_LD_CAND,
    S_RD_J,
    S_CMP,
    S_EVAL,
    S_MEAN,
    S_OUT
  } state_e;

  state_e  state_q;
  logic [IW-1:0] i_q;
  logic [IW-1:0] j_q;
  logic [CW-1:0] ch_q;

  logic signed [SAMPLE_BITS-1:0] cand_q;
  logic signed [SAMPLE_BITS-1:0] lo_q;
  logic signed [SAMPLE_BITS-1:0] hi_q;
  logic signed [FIELD_BITS-1:0]  res_q [CHANNELS];
  logic signed [FIELD_BITS-1:0]  out_q [CHANNELS];
  logic                          out_vld_q;

  logic                  in_fire;
  logic                  out_load;
  logic                  wr_en;
  logic [ROWW-1:0]       wr_row;
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic [ROWW-1:0]       rd_row;
  logic signed [SAMPLE_BITS-1:0] row_sel;
  rank_ctl_t             rank_ctl;
  logic [CNTW-1:0]       lt_cnt;
  logic [CNTW-1:0]       eq_cnt;
  logic [CNTW-1:0]       le_cnt;
  logic                  hit_hi;
  logic                  hit_lo;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic signed [SAMPLE_BITS-1:0] pick;
  logic signed [63:0]    pick_ext;
  logic [FIELD_BITS-1:0] fld [NUM_FIELDS];
  logic signed [FIELD_BITS-1:0] med [NUM_FIELDS];

  assign in_fire = in_i.valid && in_i.ready;

  // Move finished medians out once the output register is free or being taken
  assign out_load = (state_q == S_OUT) && (!out_vld_q || out_o.ready);

  // Gather the sample fields of the input word
  assign fld[0] = in_i.sample_0;
  assign fld[1] = in_i.sample_1;
  assign fld[2] = in_i.sample_2;
  assign fld[3] = in_i.sample_3;
  assign fld[4] = in_i.sample_4;
  assign fld[5] = in_i.sample_5;
  assign fld[6] = in_i.sample_6;

  // Pack the used channels into one store row
  for (genvar c = 0; c < CHANNELS; c++) begin : g_row
    assign wr_row[c*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(fld[c]);
  end

  assign wr_en   = in_fire && (in_i.operation == OP_STORE);
  assign rd_en   = (state_q == S_RD_CAND) || (state_q == S_RD_J);
  assign rd_addr = (state_q == S_RD_CAND) ? i_q : j_q;

  scm_ring_store #(
    .WINDOW      (WINDOW),
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_row_i  (wr_row),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_row_o  (rd_row)
  );

  assign row_sel = rd_row[SAMPLE_BITS*int'(ch_q) +: SAMPLE_BITS];

  assign rank_ctl.clr = (state_q == S_LD_CAND);
  assign rank_ctl.en  = (state_q == S_CMP);

  scm_rank_unit #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNTW        (CNTW)
  ) u_rank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (rank_ctl),
    .cand_i  (cand_q),
    .value_i (row_sel),
    .lt_o    (lt_cnt),
    .eq_o    (eq_cnt)
  );

  // Candidate sits at sorted place m when lt <= m < lt + eq
  assign le_cnt = lt_cnt + eq_cnt;
  assign hit_hi = (lt_cnt <= CNTW'(MHI)) && (CNTW'(MHI) < le_cnt);
  assign hit_lo = (lt_cnt <= CNTW'(MLO)) && (CNTW'(MLO) < le_cnt);

  // Floor mean of the two middle values without overflow
  assign mean     = (lo_q & hi_q) + ((lo_q ^ hi_q) >>> 1);
  assign pick     = ODD ? hi_q : mean;
  assign pick_ext = 64'(pick);

  // Sequencer: channel, candidate and compare loops, then the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      ch_q      <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '{default: '0};
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire && (in_i.operation == OP_QUERY)) begin
            state_q <= S_RD_CAND;
            i_q     <= '0;
            j_q     <= '0;
            ch_q    <= '0;
          end
        end
        S_RD_CAND: state_q <= S_LD_CAND;
        S_LD_CAND: begin
          state_q <= S_RD_J;
          j_q     <= '0;
        end
        S_RD_J: state_q <= S_CMP;
        S_CMP: begin
          if (j_q == IW'(WINDOW - 1)) begin
            state_q <= S_EVAL;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_RD_J;
          end
        end
        S_EVAL: begin
          if (i_q == IW'(WINDOW - 1)) begin
            state_q <= S_MEAN;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_RD_CAND;
          end
        end
        S_MEAN: begin
          i_q <= '0;
          if (ch_q == CW'(CHANNELS - 1)) begin
            state_q <= S_OUT;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= S_RD_CAND;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // Load a new result word or drop the one just taken
      if (out_load) begin
        out_vld_q <= 1'b1;
        out_q     <= res_q;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Hold candidate, middle values and finished medians
  always_ff @(posedge clk_i) begin
    if (state_q == S_LD_CAND) begin
      cand_q <= row_sel;
    end
    if (state_q == S_EVAL) begin
      if (hit_hi) begin
        hi_q <= cand_q;
      end
      if (hit_lo) begin
        lo_q <= cand_q;
      end
    end
    if (state_q == S_MEAN) begin
      res_q[ch_q] <= pick_ext[FIELD_BITS-1:0];
    end
  end

  // Drive zero on channels that are not built
  for (genvar c = 0; c < NUM_FIELDS; c++) begin : g_med
    if (c < CHANNELS) begin : g_used
      assign med[c] = out_q[c];
    end else begin : g_unused
      assign med[c] = '0;
    end
  end

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_vld_q;
  assign out_o.median_0 = med[0];
  assign out_o.median_1 = med[1];
  assign out_o.median_2 = med[2];
  assign out_o.median_3 = med[3];
  assign out_o.median_4 = med[4];
  assign out_o.median_5 = med[5];
  assign out_o.median_6 = med[6];

  // A waiting result word stays put until it is taken
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid &&
      $stable({out_o.median_0, out_o.median_1, out_o.median_2, out_o.median_3,
               out_o.median_4, out_o.median_5, out_o.median_6})))
    else $error("result changed or dropped while waiting");

  // A query word makes the block busy at once
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.operation == OP_QUERY)) |=> !in_i.ready)
    else $error("block still ready after a query word");

  // A store word leaves the block ready in the next cycle
  a_store_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.operation == OP_STORE)) |=> in_i.ready)
    else $error("store word did not complete in one cycle");

  // Rank counts never exceed the window
  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> (int'(lt_cnt) + int'(eq_cnt) <= WINDOW && eq_cnt != '0))
    else $error("rank counts out of range");

endmodule
